### rtl/core/rrd_pkg.sv
// Shared types, widths, register indexes and helpers of the remote report decoder.
package rrd_pkg;

   localparam int MUL_A_W = 17;
   localparam int MUL_B_W = 34;
   localparam int MUL_P_W = MUL_A_W + MUL_B_W;
   localparam int FRAC_W = 24;
   localparam int FACTOR_W = 33;
   localparam logic [FACTOR_W-1:0] FACTOR_ONE = FACTOR_W'(1) << FRAC_W;

   typedef logic [2:0] csr_index_type;
   localparam csr_index_type CSR_GAIN_X = 3'd0;
   localparam csr_index_type CSR_GAIN_Y = 3'd1;
   localparam csr_index_type CSR_LIMIT_X = 3'd2;
   localparam csr_index_type CSR_LIMIT_Y = 3'd3;
   localparam csr_index_type CSR_MOVE_THRESHOLD = 3'd4;

   localparam logic [15:0] GAIN_RESET = 16'd848;
   localparam logic [14:0] LIMIT_RESET = 15'd8192;
   localparam logic [7:0] THRESHOLD_RESET = 8'd5;

   typedef enum logic [10:0] {
      ST_IDLE   = 11'b000_0000_0001,
      ST_SQX    = 11'b000_0000_0010,
      ST_SQY    = 11'b000_0000_0100,
      ST_PX     = 11'b000_0000_1000,
      ST_FX     = 11'b000_0001_0000,
      ST_MX     = 11'b000_0010_0000,
      ST_PY     = 11'b000_0100_0000,
      ST_FY     = 11'b000_1000_0000,
      ST_MY     = 11'b001_0000_0000,
      ST_RY     = 11'b010_0000_0000,
      ST_FINISH = 11'b100_0000_0000
   } state_type;

   // Clips a scaled stick value to the signed byte range and adds the center offset.
   function automatic logic [7:0] clip_offset(input logic signed [MUL_P_W-FRAC_W-1:0] q);
      logic [7:0] res;
      if (q > 127) begin
         res = 8'hFF;
      end else if (q < -128) begin
         res = 8'h00;
      end else begin
         res = {~q[7], q[6:0]};
      end
      return res;
   endfunction

endpackage

### rtl/core/rrd_mul_unit.sv
// Shared signed multiplier with a registered product.
module rrd_mul_unit (
   input  logic                                 clock,
   input  logic signed [rrd_pkg::MUL_A_W-1:0]   mul_a,
   input  logic signed [rrd_pkg::MUL_B_W-1:0]   mul_b,
   output logic signed [rrd_pkg::MUL_P_W-1:0]   product
);

   logic signed [rrd_pkg::MUL_P_W-1:0] product_ff;
   logic signed [rrd_pkg::MUL_P_W-1:0] product_in;

   assign product_in = mul_a * mul_b;

   always_ff @(posedge clock) begin
      product_ff <= product_in;
   end

   assign product = product_ff;

endmodule

### rtl/core/remote_report_decoder_unit.sv
// Top level of the remote report decoder: report decode, dials, stick latch and fisheye scaling.
// A word that gives no result leaves the block idle; a report with the stick held goes
// straight to the finish state, and one with the stick released makes six passes through
// the one shared multiplier. The next word is taken once the result is in the output
// register. Synchronous reset restores the register defaults, clears the dials and the
// status memory, releases both stick latches and arms the first latch.
module remote_report_decoder_unit (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_write_en,
   input  rrd_pkg::csr_index_type        csr_index,
   input  logic [15:0]                   csr_data,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_mode,
   input  logic [7:0]                    req_report_kind,
   input  logic [7:0]                    req_status_byte,
   input  logic [7:0]                    req_raw_x,
   input  logic [7:0]                    req_raw_y,
   input  logic [7:0]                    req_dial_ab,
   input  logic [7:0]                    req_dial_cd,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_button_event,
   output logic                          rsp_button_level,
   output logic                          rsp_dial_event,
   output logic signed [7:0]             rsp_dial0,
   output logic signed [7:0]             rsp_dial1,
   output logic signed [7:0]             rsp_dial2,
   output logic signed [7:0]             rsp_dial3,
   output logic                          rsp_stick_event,
   output logic [7:0]                    rsp_stick_x_out,
   output logic [7:0]                    rsp_stick_y_out
);

   rrd_pkg::state_type state_ff, state_in;
   logic [15:0] gain_x_ff, gain_x_in, gain_y_ff, gain_y_in;
   logic [14:0] limit_x_ff, limit_x_in, limit_y_ff, limit_y_in;
   logic [7:0]  thr_ff, thr_in;
   logic [7:0]  last_tag_ff, last_tag_in;
   logic        first_ff, first_in;
   logic        held_x_ff, held_x_in, held_y_ff, held_y_in;
   logic [7:0]  latch_x_ff, latch_x_in, latch_y_ff, latch_y_in;
   logic [7:0]  dial0_ff, dial0_in, dial1_ff, dial1_in, dial2_ff, dial2_in, dial3_ff, dial3_in;
   logic [14:0] prev_sq_y_ff, prev_sq_y_in;
   logic        rsp_valid_ff, rsp_valid_in;

   logic signed [8:0] sx_ff, sx_in, sy_ff, sy_in;
   logic [14:0] sqx_ff, sqx_in, sqy_ff, sqy_in;
   logic [rrd_pkg::FACTOR_W-1:0] factor_ff, factor_in;
   logic [7:0]  x_res_ff, x_res_in, y_res_ff, y_res_in;
   logic        stick_on_ff, stick_on_in;
   logic        btn_event_ff, btn_event_in, btn_level_ff, btn_level_in;
   logic        dial_ev_ff, dial_ev_in;

   logic        o_btn_event_ff, o_btn_event_in, o_btn_level_ff, o_btn_level_in;
   logic        o_dial_ev_ff, o_dial_ev_in, o_stick_ff, o_stick_in;
   logic [7:0]  o_dial0_ff, o_dial0_in, o_dial1_ff, o_dial1_in;
   logic [7:0]  o_dial2_ff, o_dial2_in, o_dial3_ff, o_dial3_in;
   logic [7:0]  o_x_ff, o_x_in, o_y_ff, o_y_in;

   logic signed [rrd_pkg::MUL_A_W-1:0] mul_a;
   logic signed [rrd_pkg::MUL_B_W-1:0] mul_b;
   logic signed [rrd_pkg::MUL_P_W-1:0] product;

   logic        accept;
   logic        set_latch;
   logic [7:0]  lx, ly;
   logic        hx, hy;

   function automatic logic [7:0] nib_ext(input logic [3:0] n);
      return {{4{n[3]}}, n};
   endfunction

   function automatic logic beyond(input logic [7:0] a, input logic [7:0] b,
                                   input logic [7:0] t);
      logic [8:0] d;
      d = (a >= b) ? ({1'b0, a} - {1'b0, b}) : ({1'b0, b} - {1'b0, a});
      return d > {1'b0, t};
   endfunction

   rrd_mul_unit u_mul (
      .clock   (clock),
      .mul_a   (mul_a),
      .mul_b   (mul_b),
      .product (product)
   );

   assign req_stall = (state_ff != rrd_pkg::ST_IDLE);
   assign accept = req_valid & ~req_stall;
   assign set_latch = req_status_byte[0] | first_ff;
   assign lx = set_latch ? req_raw_x : latch_x_ff;
   assign ly = set_latch ? req_raw_y : latch_y_ff;
   assign hx = (set_latch | held_x_ff) & ~beyond(lx, req_raw_x, thr_ff);
   assign hy = (set_latch | held_y_ff) & ~beyond(ly, req_raw_y, thr_ff);

   always_comb begin
      gain_x_in = gain_x_ff;
      gain_y_in = gain_y_ff;
      limit_x_in = limit_x_ff;
      limit_y_in = limit_y_ff;
      thr_in = thr_ff;
      if (csr_write_en) begin
         case (csr_index)
            rrd_pkg::CSR_GAIN_X: gain_x_in = csr_data;
            rrd_pkg::CSR_GAIN_Y: gain_y_in = csr_data;
            rrd_pkg::CSR_LIMIT_X: limit_x_in = csr_data[14:0];
            rrd_pkg::CSR_LIMIT_Y: limit_y_in = csr_data[14:0];
            rrd_pkg::CSR_MOVE_THRESHOLD: thr_in = csr_data[7:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in = state_ff;
      last_tag_in = last_tag_ff;
      first_in = first_ff;
      held_x_in = held_x_ff;
      held_y_in = held_y_ff;
      latch_x_in = latch_x_ff;
      latch_y_in = latch_y_ff;
      dial0_in = dial0_ff;
      dial1_in = dial1_ff;
      dial2_in = dial2_ff;
      dial3_in = dial3_ff;
      prev_sq_y_in = prev_sq_y_ff;
      sx_in = sx_ff;
      sy_in = sy_ff;
      sqx_in = sqx_ff;
      sqy_in = sqy_ff;
      factor_in = factor_ff;
      x_res_in = x_res_ff;
      y_res_in = y_res_ff;
      stick_on_in = stick_on_ff;
      btn_event_in = btn_event_ff;
      btn_level_in = btn_level_ff;
      dial_ev_in = dial_ev_ff;
      o_btn_event_in = o_btn_event_ff;
      o_btn_level_in = o_btn_level_ff;
      o_dial_ev_in = o_dial_ev_ff;
      o_stick_in = o_stick_ff;
      o_dial0_in = o_dial0_ff;
      o_dial1_in = o_dial1_ff;
      o_dial2_in = o_dial2_ff;
      o_dial3_in = o_dial3_ff;
      o_x_in = o_x_ff;
      o_y_in = o_y_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      mul_a = '0;
      mul_b = '0;

      case (state_ff)
         rrd_pkg::ST_IDLE: begin
            if (accept) begin
               if (req_mode) begin
                  first_in = 1'b1;
               end else if (req_status_byte != last_tag_ff) begin
                  last_tag_in = req_status_byte;
                  if (req_report_kind[7:4] == 4'd0) begin
                     dial0_in = dial0_ff + nib_ext(req_dial_ab[3:0]);
                     dial1_in = dial1_ff + nib_ext(req_dial_ab[7:4]);
                     dial2_in = dial2_ff + nib_ext(req_dial_cd[7:4]);
                     dial3_in = dial3_ff + nib_ext(req_dial_cd[3:0]);
                     first_in = 1'b0;
                     latch_x_in = lx;
                     latch_y_in = ly;
                     held_x_in = hx;
                     held_y_in = hy;
                     btn_event_in = req_status_byte[1];
                     btn_level_in = req_status_byte[0];
                     dial_ev_in = (req_dial_ab != 8'd0) || (req_dial_cd != 8'd0);
                     sx_in = $signed({1'b0, req_raw_x}) - 9'sd128;
                     sy_in = $signed({1'b0, req_raw_y}) - 9'sd128;
                     if (!hx && !hy) begin
                        stick_on_in = 1'b1;
                        state_in = rrd_pkg::ST_SQX;
                     end else begin
                        stick_on_in = 1'b0;
                        x_res_in = 8'd0;
                        y_res_in = 8'd0;
                        state_in = rrd_pkg::ST_FINISH;
                     end
                  end
               end
            end
         end
         rrd_pkg::ST_SQX: begin
            mul_a = {{8{sx_ff[8]}}, sx_ff};
            mul_b = {{25{sx_ff[8]}}, sx_ff};
            state_in = rrd_pkg::ST_SQY;
         end
         rrd_pkg::ST_SQY: begin
            sqx_in = (product[14:0] > limit_x_ff) ? limit_x_ff : product[14:0];
            mul_a = {{8{sy_ff[8]}}, sy_ff};
            mul_b = {{25{sy_ff[8]}}, sy_ff};
            state_in = rrd_pkg::ST_PX;
         end
         rrd_pkg::ST_PX: begin
            sqy_in = (product[14:0] > limit_y_ff) ? limit_y_ff : product[14:0];
            mul_a = {2'b00, prev_sq_y_ff};
            mul_b = {18'd0, gain_x_ff};
            state_in = rrd_pkg::ST_FX;
         end
         rrd_pkg::ST_FX: begin
            factor_in = product[rrd_pkg::FACTOR_W-1:0] + rrd_pkg::FACTOR_ONE;
            state_in = rrd_pkg::ST_MX;
         end
         rrd_pkg::ST_MX: begin
            mul_a = {{8{sx_ff[8]}}, sx_ff};
            mul_b = {1'b0, factor_ff};
            state_in = rrd_pkg::ST_PY;
         end
         rrd_pkg::ST_PY: begin
            x_res_in = rrd_pkg::clip_offset(product[rrd_pkg::MUL_P_W-1:rrd_pkg::FRAC_W]);
            mul_a = {2'b00, sqx_ff};
            mul_b = {18'd0, gain_y_ff};
            state_in = rrd_pkg::ST_FY;
         end
         rrd_pkg::ST_FY: begin
            factor_in = product[rrd_pkg::FACTOR_W-1:0] + rrd_pkg::FACTOR_ONE;
            state_in = rrd_pkg::ST_MY;
         end
         rrd_pkg::ST_MY: begin
            mul_a = {{8{sy_ff[8]}}, sy_ff};
            mul_b = {1'b0, factor_ff};
            state_in = rrd_pkg::ST_RY;
         end
         rrd_pkg::ST_RY: begin
            y_res_in = rrd_pkg::clip_offset(product[rrd_pkg::MUL_P_W-1:rrd_pkg::FRAC_W]);
            prev_sq_y_in = sqy_ff;
            state_in = rrd_pkg::ST_FINISH;
         end
         rrd_pkg::ST_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               o_btn_event_in = btn_event_ff;
               o_btn_level_in = btn_level_ff;
               o_dial_ev_in = dial_ev_ff;
               o_stick_in = stick_on_ff;
               o_dial0_in = dial0_ff;
               o_dial1_in = dial1_ff;
               o_dial2_in = dial2_ff;
               o_dial3_in = dial3_ff;
               o_x_in = x_res_ff;
               o_y_in = y_res_ff;
               state_in = rrd_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = rrd_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rrd_pkg::ST_IDLE;
         gain_x_ff <= rrd_pkg::GAIN_RESET;
         gain_y_ff <= rrd_pkg::GAIN_RESET;
         limit_x_ff <= rrd_pkg::LIMIT_RESET;
         limit_y_ff <= rrd_pkg::LIMIT_RESET;
         thr_ff <= rrd_pkg::THRESHOLD_RESET;
         last_tag_ff <= 8'd0;
         first_ff <= 1'b1;
         held_x_ff <= 1'b0;
         held_y_ff <= 1'b0;
         dial0_ff <= 8'd0;
         dial1_ff <= 8'd0;
         dial2_ff <= 8'd0;
         dial3_ff <= 8'd0;
         prev_sq_y_ff <= 15'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         gain_x_ff <= gain_x_in;
         gain_y_ff <= gain_y_in;
         limit_x_ff <= limit_x_in;
         limit_y_ff <= limit_y_in;
         thr_ff <= thr_in;
         last_tag_ff <= last_tag_in;
         first_ff <= first_in;
         held_x_ff <= held_x_in;
         held_y_ff <= held_y_in;
         dial0_ff <= dial0_in;
         dial1_ff <= dial1_in;
         dial2_ff <= dial2_in;
         dial3_ff <= dial3_in;
         prev_sq_y_ff <= prev_sq_y_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      latch_x_ff <= latch_x_in;
      latch_y_ff <= latch_y_in;
      sx_ff <= sx_in;
      sy_ff <= sy_in;
      sqx_ff <= sqx_in;
      sqy_ff <= sqy_in;
      factor_ff <= factor_in;
      x_res_ff <= x_res_in;
      y_res_ff <= y_res_in;
      stick_on_ff <= stick_on_in;
      btn_event_ff <= btn_event_in;
      btn_level_ff <= btn_level_in;
      dial_ev_ff <= dial_ev_in;
      o_btn_event_ff <= o_btn_event_in;
      o_btn_level_ff <= o_btn_level_in;
      o_dial_ev_ff <= o_dial_ev_in;
      o_stick_ff <= o_stick_in;
      o_dial0_ff <= o_dial0_in;
      o_dial1_ff <= o_dial1_in;
      o_dial2_ff <= o_dial2_in;
      o_dial3_ff <= o_dial3_in;
      o_x_ff <= o_x_in;
      o_y_ff <= o_y_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_button_event = o_btn_event_ff;
   assign rsp_button_level = o_btn_level_ff;
   assign rsp_dial_event = o_dial_ev_ff;
   assign rsp_dial0 = o_dial0_ff;
   assign rsp_dial1 = o_dial1_ff;
   assign rsp_dial2 = o_dial2_ff;
   assign rsp_dial3 = o_dial3_ff;
   assign rsp_stick_event = o_stick_ff;
   assign rsp_stick_x_out = o_x_ff;
   assign rsp_stick_y_out = o_y_ff;

endmodule
